/* sv/isct_pkg.sv */
package isct_pkg;

   // Default table depth
   localparam int CAPACITY_DEF = 64;

   // Field widths
   localparam int ID_W          = 32;
   localparam int SUP_W         = 32;
   localparam int ENTRY_COUNT_W = 7;
   localparam int OP_W          = 2;

   // Operation codes
   localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
   localparam logic [OP_W-1:0] OP_PRUNE = 2'd2;

   // One table entry as held in the memory
   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [SUP_W-1:0] sup;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic start;     // latch a new transaction, rewind the scan
      logic scan;      // step the table scan
      logic seek;      // compare scanned ids against the item
      logic prune;     // compact survivors during the scan
      logic commit;    // survivors become the table size
      logic update;    // bump a hit, or append the item
      logic load_rsp;  // move the result into the output register
   } isct_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic hit;        // entry under compare holds the item id
      logic scan_done;  // every entry read and compared
   } isct_status_type;

endpackage

/* sv/item_support_count_table_core.sv */
// Steps: an add or query scans the table until a hit, and an add then updates the entry
// or appends the item; a prune scans the whole table; an unused op code goes straight
// to the result.
// Throughput: one transaction at a time, the scan reading one entry per cycle; a new
// request is taken while a result waits in the output register.
// Reset clears the entry count, threshold and control; table contents need no clearing.
module item_support_count_table_core #(
   parameter int CAPACITY = isct_pkg::CAPACITY_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [isct_pkg::OP_W-1:0]            req_op,
   input  logic signed [isct_pkg::ID_W-1:0]     req_item_id,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_found,
   output logic                                 rsp_dropped,
   output logic [isct_pkg::SUP_W-1:0]           rsp_support,
   output logic [isct_pkg::ENTRY_COUNT_W-1:0]   rsp_entry_count,
   input  logic                                 csr_wr_en,
   input  logic [isct_pkg::SUP_W-1:0]           csr_wr_data
);
   import isct_pkg::*;

   isct_cmd_type    cmd;
   isct_status_type status;

   // Sequencer
   isct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Table store, scan and result
   isct_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_item_id     (req_item_id),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_found       (rsp_found),
      .rsp_dropped     (rsp_dropped),
      .rsp_support     (rsp_support),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

/* sv/isct_ctrl.sv */
module isct_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [isct_pkg::OP_W-1:0]    req_op,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output isct_pkg::isct_cmd_type       cmd,
   input  isct_pkg::isct_status_type    status
);
   import isct_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [OP_W-1:0]     op_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;
   logic                is_seek;
   logic                slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign is_seek   = (op_ff == OP_ADD) || (op_ff == OP_QUERY);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.start    = accept;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if ((req_op == OP_ADD) || (req_op == OP_QUERY) || (req_op == OP_PRUNE)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan  = 1'b1;
            cmd.seek  = is_seek;
            cmd.prune = (op_ff == OP_PRUNE);
            if (is_seek && status.hit) begin
               state_in = (op_ff == OP_ADD) ? ST_UPDATE : ST_FINISH;
            end else if (status.scan_done) begin
               cmd.commit = (op_ff == OP_PRUNE);
               state_in   = (op_ff == OP_ADD) ? ST_UPDATE : ST_FINISH;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register hand-off
   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         op_ff        <= OP_ADD;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            op_ff <= req_op;
         end
      end
   end

endmodule

/* sv/isct_dp.sv */
module isct_dp #(
   parameter int CAPACITY = isct_pkg::CAPACITY_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  isct_pkg::isct_cmd_type               cmd,
   output isct_pkg::isct_status_type            status,
   input  logic signed [isct_pkg::ID_W-1:0]     req_item_id,
   input  logic                                 csr_wr_en,
   input  logic [isct_pkg::SUP_W-1:0]           csr_wr_data,
   output logic                                 rsp_found,
   output logic                                 rsp_dropped,
   output logic [isct_pkg::SUP_W-1:0]           rsp_support,
   output logic [isct_pkg::ENTRY_COUNT_W-1:0]   rsp_entry_count
);
   import isct_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   // Entry store, undefined until written
   entry_type            mem [CAPACITY];

   // Control registers
   logic [CNT_W-1:0]     used_ff;
   logic [CNT_W-1:0]     ptr_ff;
   logic [CNT_W-1:0]     kept_ff;
   logic                 rd_vld_ff;
   logic [SUP_W-1:0]     thr_ff;

   // Working registers
   entry_type            rd_data_ff;
   logic [IDX_W-1:0]     cmp_idx_ff;
   logic [IDX_W-1:0]     hit_idx_ff;
   logic [ID_W-1:0]      id_ff;
   logic [SUP_W-1:0]     sup_ff;
   logic                 found_ff;
   logic                 dropped_ff;

   // Output register
   logic                     rsp_found_ff;
   logic                     rsp_dropped_ff;
   logic [SUP_W-1:0]         rsp_support_ff;
   logic [ENTRY_COUNT_W-1:0] rsp_entry_count_ff;

   logic                 scan_more;
   logic                 id_match;
   logic                 keep;
   logic                 room;
   logic                 prune_wr;
   logic [SUP_W-1:0]     sup_inc;
   logic [CNT_W+ENTRY_COUNT_W-1:0] used_ext;

   // Compare and status
   assign scan_more        = (ptr_ff < used_ff);
   assign id_match         = (rd_data_ff.id == id_ff);
   assign keep             = (rd_data_ff.sup <= thr_ff);
   assign room             = (used_ff < CAP_CNT);
   assign prune_wr         = cmd.scan && cmd.prune && rd_vld_ff && keep;
   assign sup_inc          = (sup_ff == '1) ? sup_ff : sup_ff + 1'b1;
   assign used_ext         = {{ENTRY_COUNT_W{1'b0}}, used_ff};
   assign status.hit       = rd_vld_ff && id_match;
   assign status.scan_done = !scan_more && !rd_vld_ff;

   // Memory: one read and one write per cycle
   always_ff @(posedge clock) begin
      if (cmd.scan && scan_more) begin
         rd_data_ff <= mem[ptr_ff[IDX_W-1:0]];
      end
      if (prune_wr) begin
         mem[kept_ff[IDX_W-1:0]] <= rd_data_ff;
      end
      if (cmd.update) begin
         if (found_ff) begin
            mem[hit_idx_ff] <= '{id: id_ff, sup: sup_inc};
         end else if (room) begin
            mem[used_ff[IDX_W-1:0]] <= '{id: id_ff, sup: SUP_W'(1)};
         end
      end
   end

   // Scan pointers, table size and threshold
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= '0;
         ptr_ff    <= '0;
         kept_ff   <= '0;
         rd_vld_ff <= 1'b0;
         thr_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         if (cmd.start) begin
            ptr_ff    <= '0;
            kept_ff   <= '0;
            rd_vld_ff <= 1'b0;
         end else if (cmd.scan) begin
            rd_vld_ff <= scan_more;
            if (scan_more) begin
               ptr_ff <= ptr_ff + 1'b1;
            end
            if (prune_wr) begin
               kept_ff <= kept_ff + 1'b1;
            end
         end
         if (cmd.update && !found_ff && room) begin
            used_ff <= used_ff + 1'b1;
         end
         if (cmd.commit) begin
            used_ff <= kept_ff;
         end
      end
   end

   // Transaction working values
   always_ff @(posedge clock) begin
      if (cmd.scan && scan_more) begin
         cmp_idx_ff <= ptr_ff[IDX_W-1:0];
      end
      if (cmd.start) begin
         id_ff      <= req_item_id;
         sup_ff     <= '0;
         found_ff   <= 1'b0;
         dropped_ff <= 1'b0;
      end else if (cmd.seek && status.hit) begin
         found_ff   <= 1'b1;
         sup_ff     <= rd_data_ff.sup;
         hit_idx_ff <= cmp_idx_ff;
      end else if (cmd.update) begin
         if (found_ff) begin
            sup_ff <= sup_inc;
         end else if (room) begin
            sup_ff <= SUP_W'(1);
         end else begin
            dropped_ff <= 1'b1;
         end
      end
      if (cmd.load_rsp) begin
         rsp_found_ff       <= found_ff;
         rsp_dropped_ff     <= dropped_ff;
         rsp_support_ff     <= sup_ff;
         rsp_entry_count_ff <= used_ext[ENTRY_COUNT_W-1:0];
      end
   end

   assign rsp_found       = rsp_found_ff;
   assign rsp_dropped     = rsp_dropped_ff;
   assign rsp_support     = rsp_support_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

endmodule

/* sv/isct_checker.sv */
module isct_checker #(
   parameter int CAPACITY = isct_pkg::CAPACITY_DEF
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic                                 rsp_found,
   input logic                                 rsp_dropped,
   input logic [isct_pkg::SUP_W-1:0]           rsp_support,
   input logic [isct_pkg::ENTRY_COUNT_W-1:0]   rsp_entry_count
);
   import isct_pkg::*;

   localparam logic [31:0] CAP_WORD = 32'(CAPACITY);

   // A waiting transaction holds its result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) && $stable(rsp_dropped)
         && $stable(rsp_support) && $stable(rsp_entry_count))
      else $error("result changed while stalled");

   // One transaction in flight: busy straight after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // A drop reports nothing found and no count, and only on a full table
   a_drop_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> !rsp_found && (rsp_support == '0)
         && (rsp_entry_count == CAP_WORD[ENTRY_COUNT_W-1:0]))
      else $error("bad dropped result");

   // A found id always has a nonzero count
   a_found_support: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> (rsp_support != '0))
      else $error("found with zero support");

endmodule

bind item_support_count_table_core isct_checker #(.CAPACITY(CAPACITY)) u_isct_checker (.*);
